// ===== rtl/core/sfcs_pkg.sv =====
package sfcs_pkg;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_PRE_CMD,
      PH_PRE_READ,
      PH_WREN,
      PH_XFER,
      PH_POST_CMD,
      PH_POST_READ,
      PH_RST2
   } phase_type;

   typedef enum logic [1:0] {
      ACT_SEND    = 2'd0,
      ACT_RELEASE = 2'd1,
      ACT_DONE    = 2'd2
   } act_type;

   localparam logic [3:0] CMD_READ   = 4'd0;
   localparam logic [3:0] CMD_WRITE  = 4'd1;
   localparam logic [3:0] CMD_SECTOR = 4'd2;
   localparam logic [3:0] CMD_BLOCK  = 4'd3;
   localparam logic [3:0] CMD_ID     = 4'd4;
   localparam logic [3:0] CMD_UID    = 4'd5;
   localparam logic [3:0] CMD_RESET  = 4'd6;
   localparam logic [3:0] CMD_WREN   = 4'd7;
   localparam logic [3:0] CMD_WRDIS  = 4'd8;

   localparam logic [7:0] OP_READ   = 8'h0B;
   localparam logic [7:0] OP_WRITE  = 8'h02;
   localparam logic [7:0] OP_SECTOR = 8'h20;
   localparam logic [7:0] OP_BLOCK  = 8'hD8;
   localparam logic [7:0] OP_STATUS = 8'h05;
   localparam logic [7:0] OP_WREN   = 8'h06;
   localparam logic [7:0] OP_ID     = 8'h90;
   localparam logic [7:0] OP_UID    = 8'h4B;
   localparam logic [7:0] OP_RST_EN = 8'h66;
   localparam logic [7:0] OP_RST    = 8'h99;
   localparam logic [7:0] OP_WRDIS  = 8'h04;
   localparam logic [7:0] FILL_RESET = 8'hA5;

   typedef struct packed {
      phase_type   phase;
      logic [3:0]  cmd;
      logic [23:0] addr;
      logic [7:0]  prog;
      logic [3:0]  count;
      logic [63:0] gathered;
   } state_type;

   typedef struct packed {
      act_type     action;
      logic [7:0]  spi_byte;
      logic [63:0] read_value;
      logic        last;
   } result_type;

   function automatic result_type make_result(act_type act, logic [7:0] b, logic [63:0] v);
      result_type r;
      r.action     = act;
      r.spi_byte   = (act == ACT_SEND) ? b : 8'd0;
      r.read_value = (act == ACT_DONE) ? v : 64'd0;
      r.last       = 1'b0;
      return r;
   endfunction

   function automatic logic [3:0] xfer_len(logic [3:0] cmd);
      logic [3:0] n;
      unique case (cmd)
         CMD_READ:              n = 4'd6;
         CMD_WRITE:             n = 4'd5;
         CMD_SECTOR, CMD_BLOCK: n = 4'd4;
         CMD_ID:                n = 4'd6;
         CMD_UID:               n = 4'd13;
         default:               n = 4'd1;
      endcase
      return n;
   endfunction

   // first byte position captured into the gathered data, past 15 means never
   function automatic logic [4:0] capture_from(logic [3:0] cmd);
      logic [4:0] n;
      unique case (cmd)
         CMD_READ: n = 5'd5;
         CMD_ID:   n = 5'd4;
         CMD_UID:  n = 5'd5;
         default:  n = 5'd16;
      endcase
      return n;
   endfunction

   function automatic logic [7:0] xfer_byte(logic [3:0] cmd, logic [3:0] k,
                                            logic [23:0] addr, logic [7:0] prog,
                                            logic [7:0] fill);
      logic [7:0] op;
      logic [7:0] b;
      unique case (cmd)
         CMD_READ:   op = OP_READ;
         CMD_WRITE:  op = OP_WRITE;
         CMD_SECTOR: op = OP_SECTOR;
         CMD_BLOCK:  op = OP_BLOCK;
         default:    op = OP_ID;
      endcase
      if (cmd == CMD_UID) begin
         b = (k == 4'd0) ? OP_UID : fill;
      end else if (cmd == CMD_RESET) begin
         b = OP_RST_EN;
      end else if (cmd == CMD_WREN) begin
         b = OP_WREN;
      end else if (cmd > CMD_UID) begin
         b = OP_WRDIS;
      end else if (k == 4'd0) begin
         b = op;
      end else if (k == 4'd1) begin
         b = (cmd == CMD_ID) ? 8'd0 : addr[23:16];
      end else if (k == 4'd2) begin
         b = (cmd == CMD_ID) ? 8'd0 : addr[15:8];
      end else if (k == 4'd3) begin
         b = (cmd == CMD_ID) ? 8'd0 : addr[7:0];
      end else if (cmd == CMD_READ) begin
         b = (k == 4'd4) ? 8'd0 : fill;
      end else if (cmd == CMD_WRITE) begin
         b = prog;
      end else begin
         b = fill;
      end
      return b;
   endfunction

endpackage

// ===== rtl/core/sfcs_step.sv =====
module sfcs_step (
   input  sfcs_pkg::state_type  cur,
   input  logic [7:0]           fill,
   input  logic                 kind,
   input  logic [3:0]           command,
   input  logic [23:0]          address,
   input  logic [7:0]           write_data,
   input  logic [7:0]           received_byte,
   output sfcs_pkg::state_type  nxt,
   output logic [1:0]           num_results,
   output sfcs_pkg::result_type res0,
   output sfcs_pkg::result_type res1
);

   logic [3:0] k_next;
   logic       is_modify;

   always_comb begin
      nxt         = cur;
      num_results = 2'd0;
      res0        = sfcs_pkg::make_result(sfcs_pkg::ACT_SEND, 8'd0, 64'd0);
      res1        = res0;
      k_next      = cur.count + 4'd1;
      is_modify   = (cur.cmd >= sfcs_pkg::CMD_WRITE) && (cur.cmd <= sfcs_pkg::CMD_BLOCK);
      if (!kind) begin
         if (cur.phase == sfcs_pkg::PH_IDLE && command <= sfcs_pkg::CMD_WRDIS) begin
            nxt.cmd      = command;
            nxt.prog     = write_data;
            nxt.count    = 4'd0;
            nxt.gathered = 64'd0;
            if (command == sfcs_pkg::CMD_SECTOR) begin
               nxt.addr = {address[11:0], 12'd0};
            end else if (command == sfcs_pkg::CMD_BLOCK) begin
               nxt.addr = {address[7:0], 16'd0};
            end else begin
               nxt.addr = address;
            end
            num_results = 2'd1;
            if (command >= sfcs_pkg::CMD_WRITE && command <= sfcs_pkg::CMD_BLOCK) begin
               res0      = sfcs_pkg::make_result(sfcs_pkg::ACT_SEND, sfcs_pkg::OP_STATUS, 64'd0);
               nxt.phase = sfcs_pkg::PH_PRE_CMD;
            end else begin
               res0 = sfcs_pkg::make_result(sfcs_pkg::ACT_SEND,
                         sfcs_pkg::xfer_byte(command, 4'd0, nxt.addr, write_data, fill), 64'd0);
               nxt.phase = sfcs_pkg::PH_XFER;
            end
         end
      end else begin
         unique case (cur.phase)
            sfcs_pkg::PH_PRE_CMD, sfcs_pkg::PH_POST_CMD: begin
               num_results = 2'd1;
               res0        = sfcs_pkg::make_result(sfcs_pkg::ACT_SEND, fill, 64'd0);
               nxt.phase   = (cur.phase == sfcs_pkg::PH_PRE_CMD) ? sfcs_pkg::PH_PRE_READ
                                                                  : sfcs_pkg::PH_POST_READ;
            end
            sfcs_pkg::PH_PRE_READ: begin
               if (received_byte[0]) begin
                  num_results = 2'd1;
                  res0        = sfcs_pkg::make_result(sfcs_pkg::ACT_SEND, fill, 64'd0);
               end else begin
                  num_results = 2'd2;
                  res0        = sfcs_pkg::make_result(sfcs_pkg::ACT_RELEASE, 8'd0, 64'd0);
                  res1        = sfcs_pkg::make_result(sfcs_pkg::ACT_SEND, sfcs_pkg::OP_WREN, 64'd0);
                  nxt.phase   = sfcs_pkg::PH_WREN;
               end
            end
            sfcs_pkg::PH_WREN: begin
               num_results = 2'd2;
               nxt.count   = 4'd0;
               res0        = sfcs_pkg::make_result(sfcs_pkg::ACT_RELEASE, 8'd0, 64'd0);
               res1        = sfcs_pkg::make_result(sfcs_pkg::ACT_SEND,
                                sfcs_pkg::xfer_byte(cur.cmd, 4'd0, cur.addr, cur.prog, fill),
                                64'd0);
               nxt.phase   = sfcs_pkg::PH_XFER;
            end
            sfcs_pkg::PH_XFER: begin
               if ({1'b0, cur.count} >= sfcs_pkg::capture_from(cur.cmd)) begin
                  nxt.gathered = {cur.gathered[55:0], received_byte};
               end
               if (k_next < sfcs_pkg::xfer_len(cur.cmd)) begin
                  num_results = 2'd1;
                  nxt.count   = k_next;
                  res0        = sfcs_pkg::make_result(sfcs_pkg::ACT_SEND,
                                   sfcs_pkg::xfer_byte(cur.cmd, k_next, cur.addr, cur.prog, fill),
                                   64'd0);
               end else begin
                  num_results = 2'd2;
                  nxt.count   = 4'd0;
                  res0        = sfcs_pkg::make_result(sfcs_pkg::ACT_RELEASE, 8'd0, 64'd0);
                  if (is_modify) begin
                     res1      = sfcs_pkg::make_result(sfcs_pkg::ACT_SEND,
                                                       sfcs_pkg::OP_STATUS, 64'd0);
                     nxt.phase = sfcs_pkg::PH_POST_CMD;
                  end else if (cur.cmd == sfcs_pkg::CMD_RESET) begin
                     res1      = sfcs_pkg::make_result(sfcs_pkg::ACT_SEND, sfcs_pkg::OP_RST, 64'd0);
                     nxt.phase = sfcs_pkg::PH_RST2;
                  end else begin
                     res1      = sfcs_pkg::make_result(sfcs_pkg::ACT_DONE, 8'd0, nxt.gathered);
                     nxt.phase = sfcs_pkg::PH_IDLE;
                  end
               end
            end
            sfcs_pkg::PH_POST_READ: begin
               if (received_byte[0]) begin
                  num_results = 2'd1;
                  res0        = sfcs_pkg::make_result(sfcs_pkg::ACT_SEND, fill, 64'd0);
               end else begin
                  num_results = 2'd2;
                  res0        = sfcs_pkg::make_result(sfcs_pkg::ACT_RELEASE, 8'd0, 64'd0);
                  res1        = sfcs_pkg::make_result(sfcs_pkg::ACT_DONE, 8'd0, 64'd0);
                  nxt.phase   = sfcs_pkg::PH_IDLE;
               end
            end
            sfcs_pkg::PH_RST2: begin
               num_results = 2'd2;
               res0        = sfcs_pkg::make_result(sfcs_pkg::ACT_RELEASE, 8'd0, 64'd0);
               res1        = sfcs_pkg::make_result(sfcs_pkg::ACT_DONE, 8'd0, 64'd0);
               nxt.phase   = sfcs_pkg::PH_IDLE;
            end
            sfcs_pkg::PH_IDLE: begin
               nxt.phase = sfcs_pkg::PH_IDLE;
            end
         endcase
      end
      if (num_results == 2'd1) begin
         res0.last = 1'b1;
      end
      if (num_results == 2'd2) begin
         res1.last = 1'b1;
      end
   end

endmodule

// ===== rtl/core/spi_flash_command_sequencer.sv =====
// the first result of an item is shown on the rsp side in the cycle after it is taken
// throughput: one item per cycle for items with one result while rsp_tready is high; an
//   item with two results fills the two-entry buffer until its first result is popped
// reset: synchronous, active high; sequencer idle, result buffer empty, fill byte 0xA5
module spi_flash_command_sequencer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // command[3:0], address[27:4], write_data[35:28],
                                   // received_byte[43:36], zeros[47:44]
   input  logic        req_tuser,  // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,  // spi_byte[7:0], read_value[71:8]
   output logic [1:0]  rsp_tuser,  // action
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [7:0]  csr_wdata
);

   sfcs_pkg::state_type  state_ff, state_in, step_state;
   sfcs_pkg::result_type head_ff, head_in, tail_ff, tail_in, res0, res1;
   logic                 head_valid_ff, head_valid_in, tail_valid_ff, tail_valid_in;
   logic [7:0]           fill_ff;
   logic [1:0]           num_results;
   logic                 accept, pop;

   assign accept = req_tvalid && req_tready;
   assign pop    = head_valid_ff && rsp_tready;

   assign req_tready = !head_valid_ff || (!tail_valid_ff && rsp_tready);

   sfcs_step u_step (
      .cur           (state_ff),
      .fill          (fill_ff),
      .kind          (req_tuser),
      .command       (req_tdata[3:0]),
      .address       (req_tdata[27:4]),
      .write_data    (req_tdata[35:28]),
      .received_byte (req_tdata[43:36]),
      .nxt           (step_state),
      .num_results   (num_results),
      .res0          (res0),
      .res1          (res1)
   );

   always_comb begin
      state_in      = accept ? step_state : state_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      head_valid_in = head_valid_ff && !pop;
      tail_valid_in = tail_valid_ff;
      if (pop && tail_valid_ff) begin
         head_in       = tail_ff;
         head_valid_in = 1'b1;
         tail_valid_in = 1'b0;
      end
      // head and tail are both free here whenever an item is taken
      if (accept && num_results != 2'd0) begin
         head_in       = res0;
         head_valid_in = 1'b1;
         if (num_results == 2'd2) begin
            tail_in       = res1;
            tail_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= '0;
         head_valid_ff <= 1'b0;
         tail_valid_ff <= 1'b0;
         fill_ff       <= sfcs_pkg::FILL_RESET;
      end else begin
         state_ff      <= state_in;
         head_valid_ff <= head_valid_in;
         tail_valid_ff <= tail_valid_in;
         if (csr_we) begin
            fill_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   assign rsp_tvalid = head_valid_ff;
   assign rsp_tdata  = {head_ff.read_value, head_ff.spi_byte};
   assign rsp_tuser  = head_ff.action;
   assign rsp_tlast  = head_ff.last;

`ifndef ASSERT_OFF
   a_tail_needs_head: assert property (@(posedge clock) disable iff (reset)
      tail_valid_ff |-> head_valid_ff)
      else $error("second result held without a first");

   a_ready_tail_free: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !tail_valid_ff)
      else $error("item taken while the result buffer is full");

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == sfcs_pkg::ACT_DONE) |-> rsp_tlast)
      else $error("completion not marked last");

   a_idle_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff.phase == sfcs_pkg::PH_IDLE && !accept) |=> state_ff.phase == sfcs_pkg::PH_IDLE)
      else $error("sequencer left idle without an item");
`endif

endmodule
